// ===== hdl/lfu_pkg.sv =====
// Shared types and constants for the LFU cache table.
`default_nettype none
package lfu_pkg;
  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CAP_BITS       = 5;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] value;
  } lfu_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lfu_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture item, restart scan
    logic scan;    // examine one slot
    logic commit;  // apply the update
  } lfu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } lfu_sts_t;
endpackage
`default_nettype wire

// ===== hdl/lfu_cache_table.sv =====
// Steps: capture the item, scan the slots in order one slot per cycle, commit the update, present the result.
// Only one item is in flight: the scan must finish before the next item can be taken.
// Reset (rst, synchronous): all slots invalid, occupancy 0, capacity 16.
// The next item is accepted once the result has been taken.
`default_nettype none
module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CAP_BITS-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lfu_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lfu_out_t                 out_data
);
  lfu_cmd_t cmd;
  lfu_sts_t sts;

  lfu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  lfu_dp #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .in_item(in_data), .cmd, .sts,
    .out_item(out_data)
  );
endmodule
`default_nettype wire

// ===== hdl/lfu_ctrl.sv =====
// Controller state machine for the LFU cache table.
`default_nettype none
module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire lfu_sts_t sts,
  output lfu_cmd_t      cmd
);
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/lfu_dp.sv =====
// Datapath: slot store, sequential scan and update for the LFU cache table.
`default_nettype none
module lfu_dp
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CAP_BITS-1:0] cfg_data,
  input  wire lfu_in_t             in_item,
  input  wire lfu_cmd_t            cmd,
  output lfu_sts_t                 sts,
  output lfu_out_t                 out_item
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [ENTRIES-1:0]    valid;
  logic [31:0]           keys   [ENTRIES];
  logic [31:0]           vals   [ENTRIES];
  logic [COUNT_BITS-1:0] counts [ENTRIES];
  logic [IW-1:0]         ranks  [ENTRIES];
  logic [OW-1:0]         occupancy;
  logic [CAP_BITS-1:0]   capacity;

  lfu_in_t        item;
  logic [IW-1:0]  idx;
  logic           found;
  logic [IW-1:0]  found_idx;
  logic           vic_ok;
  logic [IW-1:0]  vic_idx;
  logic           free_ok;
  logic [IW-1:0]  free_idx;

  // effective capacity, clamped to 1..ENTRIES
  logic [OW:0] cap_eff;
  always_comb begin
    if (capacity == '0) cap_eff = (OW+1)'(1);
    else if (32'(capacity) > ENTRIES) cap_eff = (OW+1)'(ENTRIES);
    else cap_eff = (OW+1)'(capacity);
  end

  assign sts.scan_last = (32'(idx) == ENTRIES - 1);

  // current slot beats victim when no victim yet, count lower, or equal count and older
  logic better;
  assign better = !vic_ok || counts[idx] < counts[vic_idx] ||
                  (counts[idx] == counts[vic_idx] && ranks[idx] > ranks[vic_idx]);

  // update decision
  logic          do_evict, do_insert;
  logic [IW-1:0] tgt;
  logic [IW-1:0] ev_rank;
  always_comb begin
    do_evict  = 1'b0;
    do_insert = 1'b0;
    tgt       = found_idx;
    if (item.op && !found) begin
      if ((OW+1)'(occupancy) >= cap_eff && vic_ok) begin
        do_evict = 1'b1;
        tgt = vic_idx;
      end else if (free_ok) begin
        tgt = free_idx;
      end else begin
        do_evict = vic_ok;
        tgt = vic_idx;
      end
      do_insert = do_evict || free_ok;
    end
    ev_rank = ranks[tgt];
  end

  always_ff @(posedge clk) begin
    if (rst) capacity <= CAP_BITS'(16);
    else if (cfg_we) capacity <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
    end else if (cmd.commit && do_insert) begin
      if (!do_evict) occupancy <= occupancy + OW'(1);
      valid[tgt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item    <= in_item;
      idx     <= '0;
      found   <= 1'b0;
      vic_ok  <= 1'b0;
      free_ok <= 1'b0;
    end else if (cmd.scan) begin
      if (!sts.scan_last) idx <= idx + IW'(1);
      if (valid[idx]) begin
        if (!found && keys[idx] == item.key) begin
          found <= 1'b1;
          found_idx <= idx;
        end
        if (better) begin
          vic_ok <= 1'b1;
          vic_idx <= idx;
        end
      end else if (!free_ok) begin
        free_ok <= 1'b1;
        free_idx <= idx;
      end
    end
    if (cmd.commit) begin
      out_item.hit         <= found;
      out_item.read_value  <= item.op ? 32'd0 : (found ? vals[found_idx] : '1);
      out_item.evicted     <= do_evict;
      out_item.evicted_key <= do_evict ? keys[vic_idx] : 32'd0;
      if (found) begin
        if (counts[found_idx] != CMAX) counts[found_idx] <= counts[found_idx] + 1'b1;
        if (item.op) vals[found_idx] <= item.value;
        for (int i = 0; i < ENTRIES; i++)
          if (valid[i] && IW'(i) != found_idx && ranks[i] < ranks[found_idx])
            ranks[i] <= ranks[i] + 1'b1;
        ranks[found_idx] <= '0;
      end else if (do_insert) begin
        // evict closes the gap, insert ages all: net age only slots newer than victim
        for (int i = 0; i < ENTRIES; i++)
          if (valid[i] && IW'(i) != tgt && (!do_evict || ranks[i] < ev_rank))
            ranks[i] <= ranks[i] + 1'b1;
        keys[tgt]   <= item.key;
        vals[tgt]   <= item.value;
        counts[tgt] <= COUNT_BITS'(1);
        ranks[tgt]  <= '0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lfu_checker.sv =====
// Port-level checker for the LFU cache table, bound to the top level.
`default_nettype none
module lfu_checker
  import lfu_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire lfu_out_t out_data
);
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item accepted while result pending");
  a_evk_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.evicted) |-> out_data.evicted_key == 32'd0)
    else $error("evicted_key nonzero without eviction");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.hit) |-> !out_data.evicted)
    else $error("eviction on hit");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> in_valid)
    else $error("stalled input item dropped");
endmodule
`default_nettype wire

bind lfu_cache_table lfu_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
